FILE: hdl/ves_pkg.sv
// Shared types and constants for the vector exponential smoothing unit.
// No dependencies; imported by ves_ctrl, ves_dp and the top level.
package ves_pkg;

  // Samples per transaction (one input port and one output port each).
  localparam int LANES     = 8;
  localparam int LANE_W    = $clog2(LANES);

  // Q1.15 weight format.
  localparam int WEIGHT_W  = 16;
  localparam int FRAC_BITS = 15;
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 16'h8000;
  localparam logic [WEIGHT_W-1:0] WEIGHT_RST = 16'h1000;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_SMOOTHING_WEIGHT = 1'b0,
    REG_START_LEVEL      = 1'b1
  } ves_reg_e;

  // Controller states, one-hot.
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CALC = 3'b010,
    ST_DONE = 3'b100
  } ves_state_e;

  // Controller -> datapath commands.
  typedef struct packed {
    logic load;  // capture input transaction
    logic step;  // filter one lane
    logic xfer;  // move finished results to output register
  } ves_cmd_t;

  // Datapath -> controller status.
  typedef struct packed {
    logic out_free;  // output register empty or being taken this cycle
  } ves_status_t;

endpackage : ves_pkg

FILE: hdl/ves_ctrl.sv
// Sequencing controller for the vector exponential smoothing unit.
// Depends on ves_pkg (state enum, command and status structs).
module ves_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  ves_pkg::ves_status_t  status_i,
  output ves_pkg::ves_cmd_t     cmd_o
);
  import ves_pkg::*;

  ves_state_e        state_q, state_d;
  logic [LANE_W-1:0] lane_q, lane_d;
  logic              last_lane;
  logic              accept;

  assign last_lane  = (lane_q == LANE_W'(LANES - 1));
  // ready in idle, or in the cycle the finished results leave
  assign in_stall_o = !((state_q == ST_IDLE) ||
                        ((state_q == ST_DONE) && status_i.out_free));
  assign accept     = in_valid_i && !in_stall_o;

  assign cmd_o.load = accept;
  assign cmd_o.step = (state_q == ST_CALC);
  assign cmd_o.xfer = (state_q == ST_DONE) && status_i.out_free;

  always_comb begin
    state_d = state_q;
    lane_d  = lane_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_CALC;
        end
      end
      ST_CALC: begin
        if (last_lane) begin
          lane_d  = '0;
          state_d = ST_DONE;
        end else begin
          lane_d  = lane_q + LANE_W'(1);
        end
      end
      ST_DONE: begin
        if (status_i.out_free) begin
          state_d = accept ? ST_CALC : ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
        lane_d  = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      lane_q  <= '0;
    end else begin
      state_q <= state_d;
      lane_q  <= lane_d;
    end
  end

  // a new transaction always starts at lane zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> (state_q == ST_CALC) && (lane_q == '0))
    else $error("ves_ctrl: load did not start at lane zero");

  // results never leave while lanes are still being filtered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.step && cmd_o.xfer))
    else $error("ves_ctrl: step and transfer overlap");

endmodule : ves_ctrl

FILE: hdl/ves_dp.sv
// Datapath of the vector exponential smoothing unit: config registers,
// lane shift registers, one shared multiply-add and the output register.
// Depends on ves_pkg.
module ves_dp #(
  parameter int SAMPLE_BITS = 16,
  localparam int CfgW = (SAMPLE_BITS > ves_pkg::WEIGHT_W) ? SAMPLE_BITS
                                                          : ves_pkg::WEIGHT_W
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ves_pkg::ves_cmd_t             cmd_i,
  output ves_pkg::ves_status_t          status_o,
  input  logic                          cfg_we_i,
  input  ves_pkg::ves_reg_e             cfg_index_i,
  input  logic [CfgW-1:0]               cfg_data_i,
  input  logic                          restart_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i [ves_pkg::LANES],
  output logic signed [SAMPLE_BITS-1:0] out_o    [ves_pkg::LANES],
  output logic                          out_valid_o,
  input  logic                          out_stall_i
);
  import ves_pkg::*;

  localparam int DiffW = SAMPLE_BITS + 1;
  localparam int AccW  = SAMPLE_BITS + WEIGHT_W + 2;

  logic        [WEIGHT_W-1:0]    weight_q;
  logic signed [SAMPLE_BITS-1:0] start_q;
  logic signed [SAMPLE_BITS-1:0] y_q, y_d;
  logic signed [SAMPLE_BITS-1:0] x_q   [LANES];
  logic signed [SAMPLE_BITS-1:0] res_q [LANES];
  logic signed [SAMPLE_BITS-1:0] out_q [LANES];
  logic                          out_valid_q;

  logic [WEIGHT_W-1:0]    weight_sat;
  logic [WEIGHT_W-1:0]    in_gain;
  logic signed [DiffW-1:0] diff;
  logic signed [AccW-1:0]  prod;
  logic signed [AccW-1:0]  acc;

  // w*y + (1-w)*x == y + (1-w)*(x-y): one multiplier per lane step
  assign weight_sat = (weight_q > WEIGHT_ONE) ? WEIGHT_ONE : weight_q;
  assign in_gain    = WEIGHT_ONE - weight_sat;
  assign diff       = DiffW'(x_q[0]) - DiffW'(y_q);
  assign prod       = $signed({1'b0, in_gain}) * diff;
  assign acc        = $signed({{(AccW - SAMPLE_BITS - FRAC_BITS){y_q[SAMPLE_BITS-1]}},
                                y_q, {FRAC_BITS{1'b0}}})
                      + prod + AccW'(1 << (FRAC_BITS - 1));
  // floor shift; result is a convex mix, so the slice never overflows
  assign y_d        = acc[FRAC_BITS +: SAMPLE_BITS];

  assign status_o.out_free = !out_valid_q || !out_stall_i;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_q <= WEIGHT_RST;
      start_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_SMOOTHING_WEIGHT: weight_q <= cfg_data_i[WEIGHT_W-1:0];
        REG_START_LEVEL:      start_q  <= cfg_data_i[SAMPLE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // filter state: last output of the previous transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      y_q <= '0;
    end else if (cmd_i.load) begin
      if (restart_i) begin
        y_q <= start_q;
      end
    end else if (cmd_i.step) begin
      y_q <= y_d;
    end
  end

  // lane shift registers: inputs drain from the bottom, results fill from the top
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      for (int k = 0; k < LANES; k++) begin
        x_q[k] <= sample_i[k];
      end
    end else if (cmd_i.step) begin
      for (int k = 0; k < LANES - 1; k++) begin
        x_q[k] <= x_q[k+1];
      end
    end
    if (cmd_i.step) begin
      for (int k = 0; k < LANES - 1; k++) begin
        res_q[k] <= res_q[k+1];
      end
      res_q[LANES-1] <= y_d;
    end
    if (cmd_i.xfer) begin
      for (int k = 0; k < LANES; k++) begin
        out_q[k] <= res_q[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.xfer) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_o       = out_q;
  assign out_valid_o = out_valid_q;

  // a pending result is never overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.xfer |-> !(out_valid_q && out_stall_i))
    else $error("ves_dp: output register overwritten while stalled");

  // restart seeds the recurrence from the start level
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.load && restart_i) |=> (y_q == $past(start_q)))
    else $error("ves_dp: restart did not load start level");

endmodule : ves_dp

FILE: hdl/vector_exponential_smoothing_unit.sv
// Top level of the vector exponential smoothing unit.
// Depends on ves_pkg, ves_ctrl and ves_dp.

// First-order exponential smoothing (EMA) over transactions of eight signed
// samples. Lane j gives y_j = (w*y_{j-1} + (32768-w)*x_j + 16384) >>> 15, with
// w the Q1.15 smoothing weight (values above 32768 act as 32768) and y_{-1}
// either the last output of the previous transaction or start_level when
// restart is set. The lanes form a recurrence, so one shared multiply-add
// handles one lane per cycle: a transaction is filtered lane by lane, then
// moves into the output register, and the next input transaction can be
// taken in that same cycle. The output register decouples the two sides:
// a new input is accepted while the previous result still waits. Config
// writes (index 0 weight, 1 start level) take effect at the next edge and
// are meant for idle periods only. Reset: weight 4096 (0.125), start level 0,
// last output 0.
module vector_exponential_smoothing_unit #(
  parameter int SAMPLE_BITS = 16,
  localparam int CfgW = (SAMPLE_BITS > ves_pkg::WEIGHT_W) ? SAMPLE_BITS
                                                          : ves_pkg::WEIGHT_W
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_we_i,
  input  ves_pkg::ves_reg_e             cfg_index_i,
  input  logic [CfgW-1:0]               cfg_data_i,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          restart_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_0_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_1_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_2_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_3_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_4_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_5_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_6_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_7_i,
  // output channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [SAMPLE_BITS-1:0] out_0_o,
  output logic signed [SAMPLE_BITS-1:0] out_1_o,
  output logic signed [SAMPLE_BITS-1:0] out_2_o,
  output logic signed [SAMPLE_BITS-1:0] out_3_o,
  output logic signed [SAMPLE_BITS-1:0] out_4_o,
  output logic signed [SAMPLE_BITS-1:0] out_5_o,
  output logic signed [SAMPLE_BITS-1:0] out_6_o,
  output logic signed [SAMPLE_BITS-1:0] out_7_o
);
  import ves_pkg::*;

  ves_cmd_t                      cmd;
  ves_status_t                   status;
  logic signed [SAMPLE_BITS-1:0] samples [LANES];
  logic signed [SAMPLE_BITS-1:0] outs    [LANES];

  // oldest sample in lane zero
  assign samples[0] = sample_0_i;
  assign samples[1] = sample_1_i;
  assign samples[2] = sample_2_i;
  assign samples[3] = sample_3_i;
  assign samples[4] = sample_4_i;
  assign samples[5] = sample_5_i;
  assign samples[6] = sample_6_i;
  assign samples[7] = sample_7_i;

  assign out_0_o = outs[0];
  assign out_1_o = outs[1];
  assign out_2_o = outs[2];
  assign out_3_o = outs[3];
  assign out_4_o = outs[4];
  assign out_5_o = outs[5];
  assign out_6_o = outs[6];
  assign out_7_o = outs[7];

  // sequencer: idle / filter lanes / hand off to output register
  ves_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // config registers, lane registers, multiply-add, output register
  ves_dp #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .restart_i   (restart_i),
    .sample_i    (samples),
    .out_o       (outs),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i)
  );

endmodule : vector_exponential_smoothing_unit

FILE: tb/vector_exponential_smoothing_unit_tb.sv
// Self-checking testbench for vector_exponential_smoothing_unit.
// A directed table runs first, then about a thousand random transactions. Every result is
// checked against a predictor kept in this file. Depends on ves_pkg and the unit's RTL.
module vector_exponential_smoothing_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ves_pkg::*;

  // One transaction's worth of samples. Lane 0 (the oldest sample) is the leftmost element.
  typedef logic [0:LANES-1][15:0] lane_vec_t;

  // Directed table row. The weight and level columns are used only when cfg is set.
  // When typed is set, res holds an expected result worked out by hand, and that value
  // is checked in place of the predictor's.
  typedef struct packed {
    logic      cfg;
    logic [15:0] weight;
    logic [15:0] level;
    logic      restart;
    lane_vec_t smp;
    logic      typed;
    lane_vec_t res;
  } dir_row_t;

  localparam lane_vec_t MIX_VEC = {16'h8000, 16'h7FFF, 16'h0001, 16'hFFFF,
                                   16'h0000, 16'h5555, 16'hAAAA, 16'h1234};
  localparam lane_vec_t ALT_VEC = {16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000,
                                   16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000};
  // Tie cases for round-half-up when the weight is one half.
  localparam lane_vec_t TIE_VEC = {16'h0001, 16'hFFFF, 16'h0001, 16'hFFFF,
                                   16'h0002, 16'hFFFE, 16'h0003, 16'hFFFD};
  localparam lane_vec_t PAT_VEC = {16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA,
                                   16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555};

  localparam int DIR_ROWS = 18;
  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    // The reset weight is 0.125 and the stored output is zero, so zero input gives zero.
    '{1'b0, 16'h0000, 16'h0000, 1'b0, {8{16'h0000}}, 1'b1, {8{16'h0000}}},
    '{1'b0, 16'h0000, 16'h0000, 1'b0, {8{16'h7FFF}}, 1'b0, '0},
    '{1'b0, 16'h0000, 16'h0000, 1'b1, {8{16'h8000}}, 1'b0, '0},
    '{1'b0, 16'h0000, 16'h0000, 1'b0, ALT_VEC,       1'b0, '0},
    // A weight of zero makes the output follow the input exactly.
    '{1'b1, 16'h0000, 16'h1234, 1'b1, MIX_VEC,       1'b1, MIX_VEC},
    '{1'b0, 16'h0000, 16'h0000, 1'b0, {8{16'h7FFF}}, 1'b1, {8{16'h7FFF}}},
    '{1'b0, 16'h0000, 16'h0000, 1'b0, {8{16'h8000}}, 1'b1, {8{16'h8000}}},
    // A weight of one holds the previous output, here the start level.
    '{1'b1, 16'h8000, 16'h8000, 1'b1, {8{16'h7FFF}}, 1'b1, {8{16'h8000}}},
    '{1'b0, 16'h0000, 16'h0000, 1'b0, MIX_VEC,       1'b1, {8{16'h8000}}},
    // A weight above one saturates to one.
    '{1'b1, 16'hFFFF, 16'h7FFF, 1'b1, {8{16'h8000}}, 1'b1, {8{16'h7FFF}}},
    '{1'b1, 16'h8001, 16'h0000, 1'b0, {8{16'h8000}}, 1'b1, {8{16'h7FFF}}},
    '{1'b0, 16'h0000, 16'h0000, 1'b1, MIX_VEC,       1'b1, {8{16'h0000}}},
    // The largest weight below one, and the smallest weight above zero.
    '{1'b1, 16'h7FFF, 16'h8000, 1'b1, {8{16'h7FFF}}, 1'b0, '0},
    '{1'b0, 16'h0000, 16'h0000, 1'b0, {8{16'h8000}}, 1'b0, '0},
    '{1'b1, 16'h0001, 16'h7FFF, 1'b1, {8{16'h8000}}, 1'b0, '0},
    '{1'b1, 16'h4000, 16'h0000, 1'b1, TIE_VEC,       1'b0, '0},
    '{1'b0, 16'h0000, 16'h0000, 1'b0, PAT_VEC,       1'b0, '0},
    // Return to the reset setting.
    '{1'b1, 16'h1000, 16'h0000, 1'b1, {8{16'h0000}}, 1'b1, {8{16'h0000}}}
  };

  localparam int          RAND_PHASES = 10;
  localparam int          TAIL_CYCLES = 16;
  localparam int unsigned CYCLE_LIMIT = 400_000;
  localparam longint      UNITY       = longint'(WEIGHT_ONE);
  localparam longint      HALF_LSB    = longint'(1) << (FRAC_BITS - 1);

  // DUT-facing signals. All of the driven ones are known from time zero.
  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  ves_reg_e    cfg_index_i = REG_SMOOTHING_WEIGHT;
  logic [15:0] cfg_data_i  = '0;
  logic        in_valid_i  = 1'b0;
  logic        restart_i   = 1'b0;
  lane_vec_t   samples_drv = '0;
  logic        out_stall_i = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  lane_vec_t   dut_res;

  // Predictor state, plus a mirror of the configuration.
  logic [15:0]        ema_weight = WEIGHT_RST;
  logic signed [15:0] ema_start  = '0;
  logic signed [15:0] ema_last   = '0;
  lane_vec_t          ema_expect_q [$];

  logic        idle_on    = 1'b1;  // random gaps and stalls allowed
  int          stall_left = 0;
  int          fail_cnt   = 0;
  int unsigned cycle_cnt  = 0;

  vector_exponential_smoothing_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .restart_i   (restart_i),
    .sample_0_i  (samples_drv[0]),
    .sample_1_i  (samples_drv[1]),
    .sample_2_i  (samples_drv[2]),
    .sample_3_i  (samples_drv[3]),
    .sample_4_i  (samples_drv[4]),
    .sample_5_i  (samples_drv[5]),
    .sample_6_i  (samples_drv[6]),
    .sample_7_i  (samples_drv[7]),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_0_o     (dut_res[0]),
    .out_1_o     (dut_res[1]),
    .out_2_o     (dut_res[2]),
    .out_3_o     (dut_res[3]),
    .out_4_o     (dut_res[4]),
    .out_5_o     (dut_res[5]),
    .out_6_o     (dut_res[6]),
    .out_7_o     (dut_res[7])
  );

  always #1 clk_i = ~clk_i;

  // Run the EMA recurrence over the lanes of one transaction and update the stored output.
  // The arithmetic is done at 64 bits, so >>> is an exact floor divide by 2^15.
  function automatic lane_vec_t predict_ema(input logic from_start, input lane_vec_t x);
    longint    w;
    longint    y;
    longint    acc;
    lane_vec_t r;
    w = (ema_weight > WEIGHT_ONE) ? UNITY : longint'(ema_weight);
    y = from_start ? longint'(ema_start) : longint'(ema_last);
    for (int j = 0; j < LANES; j++) begin
      acc  = w * y + (UNITY - w) * longint'($signed(x[j])) + HALF_LSB;
      y    = acc >>> FRAC_BITS;
      r[j] = y[15:0];
    end
    ema_last = y[15:0];
    return r;
  endfunction

  // Random sample: full range, extremes, or small values around zero.
  function automatic logic [15:0] pick_sample(input int mode);
    logic [15:0] v;
    case (mode)
      0: v = 16'($urandom);
      1: begin
        case ($urandom_range(0, 4))
          0:       v = 16'h8000;
          1:       v = 16'h7FFF;
          2:       v = 16'h0000;
          3:       v = 16'hFFFF;
          default: v = 16'h0001;
        endcase
      end
      default: v = 16'($urandom_range(0, 511)) - 16'd256;
    endcase
    return v;
  endfunction

  // Random weight. Zero, one and the saturating range are weighted up.
  function automatic logic [15:0] pick_weight();
    logic [15:0] w;
    case ($urandom_range(0, 5))
      0:       w = 16'h0000;
      1:       w = WEIGHT_ONE;
      2:       w = 16'($urandom_range(32769, 65535));
      3:       w = 16'hFFFF;
      default: w = 16'($urandom_range(0, 32768));
    endcase
    return w;
  endfunction

  // Present one input transaction and hold it until accepted, then record the expected
  // result. This is entered right after a rising edge. Valid is kept high across
  // back-to-back transactions.
  task automatic send_samples(input logic from_start, input lane_vec_t x,
                              input logic typed, input lane_vec_t typed_res);
    int        gap;
    lane_vec_t r;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 15);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    restart_i   <= from_start;
    samples_drv <= x;
    do @(posedge clk_i); while (in_stall_o);
    r = predict_ema(from_start, x);
    ema_expect_q.push_back(typed ? typed_res : r);
  endtask

  // Stop sending, wait for every outstanding result, then let the pipeline settle.
  task automatic settle(input int tail);
    in_valid_i <= 1'b0;
    while (ema_expect_q.size() != 0) @(posedge clk_i);
    repeat (tail) @(posedge clk_i);
  endtask

  // The write enable stays high between the two writes, so it gets one assignment per step.
  task automatic write_reg(input ves_reg_e idx, input logic [15:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
  endtask

  task automatic apply_cfg(input logic [15:0] weight, input logic [15:0] level);
    write_reg(REG_SMOOTHING_WEIGHT, weight);
    write_reg(REG_START_LEVEL, level);
    cfg_we_i   <= 1'b0;
    ema_weight  = weight;
    ema_start   = level;
  endtask

  // Result side: check the accepted transaction, then choose the stall for the next cycle.
  // Both use pre-edge values, since every input is driven with NBAs.
  always @(posedge clk_i) begin
    lane_vec_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (ema_expect_q.size() == 0) begin
        $error("result transaction with no expected result pending");
        fail_cnt++;
      end else begin
        want = ema_expect_q.pop_front();
        for (int j = 0; j < LANES; j++) begin
          if (dut_res[j] !== want[j]) begin
            $error("out_%0d mismatch: expected %0d, got %0d",
                   j, $signed(want[j]), $signed(dut_res[j]));
            fail_cnt++;
          end
        end
      end
    end
    // a burst in progress ends as soon as idling is switched off
    if (idle_on && stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (idle_on && rst_ni && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 14);  // start a stall burst of random length
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int          n_items;
    int          mode;
    logic [15:0] base;
    lane_vec_t   x;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table. A config write happens only once everything in flight has drained.
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (DIR_TAB[i].cfg) begin
        settle(4);
        apply_cfg(DIR_TAB[i].weight, DIR_TAB[i].level);
      end
      send_samples(DIR_TAB[i].restart, DIR_TAB[i].smp, DIR_TAB[i].typed, DIR_TAB[i].res);
    end

    // Random phases, each with a new setting. The last phase runs at full rate.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      settle(4);
      idle_on = (ph != RAND_PHASES - 1);
      apply_cfg(pick_weight(), ($urandom_range(0, 3) == 0) ? pick_sample(1) : pick_sample(0));
      n_items = (ph == RAND_PHASES - 1) ? 150 : 95;
      for (int k = 0; k < n_items; k++) begin
        mode = $urandom_range(0, 3);
        base = 16'($urandom);
        // A flat transaction (same value in every lane) shows the output converging.
        for (int j = 0; j < LANES; j++) x[j] = (mode == 3) ? base : pick_sample(mode);
        send_samples($urandom_range(0, 7) == 0, x, 1'b0, '0);
      end
    end

    settle(TAIL_CYCLES);
    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
